// File: src/clsr_pkg.sv
`default_nettype none

package clsr_pkg;

   // field widths
   localparam int VALUE_W    = 31;
   localparam int MULT_W     = 16;
   localparam int PROD_W     = VALUE_W + MULT_W;
   localparam int DELTA_W    = 8;
   localparam int FOLD_W     = VALUE_W + 1;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   // default shuffle table depth
   localparam int TABLE_SIZE_DEF = 32;

   // Lehmer generator constants; each modulus is 2^31 minus a small delta
   localparam logic [VALUE_W-1:0] M_ONE   = 31'd2147483563;
   localparam logic [VALUE_W-1:0] M_TWO   = 31'd2147483399;
   localparam logic [MULT_W-1:0]  A_ONE   = 16'd40014;
   localparam logic [MULT_W-1:0]  A_TWO   = 16'd40692;
   localparam logic [DELTA_W-1:0] D_ONE   = 8'd85;
   localparam logic [DELTA_W-1:0] D_TWO   = 8'd249;

   // a zero seed is replaced by this value
   localparam logic [VALUE_W-1:0] SEED_SUBST = 31'd3;

   // request kinds carried on tuser
   localparam logic ACT_NEXT   = 1'b0;
   localparam logic ACT_RESEED = 1'b1;

   // generator select for the shared modular multiplier
   typedef enum logic {
      GEN_ONE = 1'b0,
      GEN_TWO = 1'b1
   } gen_sel_type;

   typedef struct packed {
      logic                valid;
      gen_sel_type         sel;
      logic [VALUE_W-1:0]  operand;
   } mm_req_type;

   typedef struct packed {
      logic                valid;
      gen_sel_type         sel;
      logic [VALUE_W-1:0]  value;
   } mm_rsp_type;

endpackage

`default_nettype wire

// File: src/clsr_ram.sv
`default_nettype none

module clsr_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/clsr_mulmod.sv
`default_nettype none

// Pipelined a*z mod m for either generator.
// m = 2^31 - d, so the high part of the product folds back as hi*d.
module clsr_mulmod (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire clsr_pkg::mm_req_type mm_req,
   output clsr_pkg::mm_rsp_type     mm_rsp
);

   import clsr_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   gen_sel_type          s1_sel_ff, s1_sel_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 s2_valid_ff, s2_valid_in;
   gen_sel_type          s2_sel_ff, s2_sel_in;
   logic [FOLD_W-1:0]    fold_ff, fold_in;
   logic                 s3_valid_ff, s3_valid_in;
   gen_sel_type          s3_sel_ff, s3_sel_in;
   logic [VALUE_W-1:0]   res_ff, res_in;

   logic [MULT_W-1:0]         mult;
   logic [DELTA_W-1:0]        delta;
   logic [VALUE_W-1:0]        modulus;
   logic [MULT_W-1:0]         prod_hi;
   logic [MULT_W+DELTA_W-1:0] hi_fold;

   // stage 1: full product
   always_comb begin
      mult        = (mm_req.sel == GEN_TWO) ? A_TWO : A_ONE;
      prod_in     = PROD_W'(mm_req.operand) * PROD_W'(mult);
      s1_valid_in = mm_req.valid;
      s1_sel_in   = mm_req.sel;
   end

   // stage 2: fold high part, result below 2*m
   always_comb begin
      delta       = (s1_sel_ff == GEN_TWO) ? D_TWO : D_ONE;
      prod_hi     = prod_ff[PROD_W-1:VALUE_W];
      hi_fold     = (MULT_W+DELTA_W)'(prod_hi) * (MULT_W+DELTA_W)'(delta);
      fold_in     = FOLD_W'(hi_fold) + FOLD_W'(prod_ff[VALUE_W-1:0]);
      s2_valid_in = s1_valid_ff;
      s2_sel_in   = s1_sel_ff;
   end

   // stage 3: one conditional subtract
   always_comb begin
      modulus     = (s2_sel_ff == GEN_TWO) ? M_TWO : M_ONE;
      if (fold_ff >= FOLD_W'(modulus)) begin
         res_in = VALUE_W'(fold_ff - FOLD_W'(modulus));
      end else begin
         res_in = fold_ff[VALUE_W-1:0];
      end
      s3_valid_in = s2_valid_ff;
      s3_sel_in   = s2_sel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
      s1_sel_ff <= s1_sel_in;
      s2_sel_ff <= s2_sel_in;
      s3_sel_ff <= s3_sel_in;
      prod_ff   <= prod_in;
      fold_ff   <= fold_in;
      res_ff    <= res_in;
   end

   assign mm_rsp.valid = s3_valid_ff;
   assign mm_rsp.sel   = s3_sel_ff;
   assign mm_rsp.value = res_ff;

   // result is always fully reduced
   a_res_reduced: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> ((s3_sel_ff == GEN_TWO) ? (res_ff < M_TWO) : (res_ff < M_ONE)))
      else $error("mulmod result not reduced");

   // the fold never needs a second subtract
   a_fold_bound: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (fold_ff < (FOLD_W'(modulus) << 1)))
      else $error("mulmod fold out of range");

endmodule

`default_nettype wire

// File: src/combined_lcg_shuffle_rng.sv
`default_nettype none

// Combined Lehmer generator (moduli 2147483563 and 2147483399) with a
// Bays-Durham shuffle table of TABLE_SIZE entries. Each request returns one
// integer in 1..2147483562; multiply by 1/2147483563 in software for a
// uniform. tuser high reseeds from the seed in tdata (zero becomes 3) before
// the number is made. Both generators step on one shared three-stage modular
// multiplier. The table slot comes from a reciprocal multiply and one
// correction, done while the two generator steps are issued.
// A plain request passes through the sequencer after it is accepted as
// two multiplier issues, a wait on the pipeline, a table read and the
// combine, which registers the result. The next request is taken only
// once the sequencer is back in idle, so one request is handled at a time.
// A reseed, and the first request after reset, adds TABLE_SIZE+8
// dependent generator steps plus a setup step. A new request is taken
// while the previous result still waits; the combine step then stalls
// until that result is taken.
module combined_lcg_shuffle_rng #(
   parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [clsr_pkg::REQ_DATA_W-1:0]   req_tdata,  // [30:0] seed, [31] zero
   input  wire logic                              req_tuser,  // [0] action
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [clsr_pkg::RSP_DATA_W-1:0]   rsp_tdata   // [30:0] value, [31] zero
);

   import clsr_pkg::*;

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int CW = $clog2(TABLE_SIZE + 8);
   localparam int DW = VALUE_W + AW;
   localparam longint M_ONE_LESS = longint'(M_ONE) - 1;
   localparam longint SLOT_DIV   = 1 + M_ONE_LESS / TABLE_SIZE;
   localparam longint SLOT_RECIP = (longint'(1) << VALUE_W) / SLOT_DIV;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT_SETUP,
      S_INIT_ISSUE,
      S_INIT_WAIT,
      S_STEP_ONE,
      S_STEP_TWO,
      S_STEP_WAIT,
      S_READ,
      S_COMBINE
   } state_type;

   state_type           state_ff, state_in;
   logic [VALUE_W-1:0]  gen_one_ff, gen_one_in;
   logic [VALUE_W-1:0]  gen_two_ff, gen_two_in;
   logic [VALUE_W-1:0]  last_out_ff, last_out_in;
   logic                need_init_ff, need_init_in;
   logic [CW-1:0]       init_cnt_ff, init_cnt_in;
   logic [AW-1:0]       quot_ff, quot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;

   mm_req_type          mm_req;
   mm_rsp_type          mm_rsp;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [VALUE_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [VALUE_W-1:0]  ram_rd_data;

   logic [VALUE_W-1:0]  seed;
   logic [DW-1:0]       slot_est;
   logic [DW-1:0]       slot_rem;
   logic                slot_bump;
   logic [FOLD_W-1:0]   diff;
   logic [FOLD_W-1:0]   diff_wrap;
   logic [VALUE_W-1:0]  y_value;
   logic                out_free;

   clsr_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   clsr_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (quot_ff),
      .rd_data (ram_rd_data)
   );

   // handshake and datapath helpers
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      seed       = req_tdata[VALUE_W-1:0];
      out_free   = !rsp_valid_ff || rsp_tready;
      // slot estimate by reciprocal multiply, low by at most one
      slot_est   = DW'(last_out_ff) * DW'(SLOT_RECIP);
      slot_rem   = DW'(last_out_ff) - DW'(quot_ff) * DW'(SLOT_DIV);
      slot_bump  = (slot_rem >= DW'(SLOT_DIV));
      diff       = FOLD_W'(ram_rd_data) - FOLD_W'(gen_two_ff);
      diff_wrap  = diff + FOLD_W'(M_ONE_LESS);
      if (diff[FOLD_W-1] || (diff == '0)) begin
         y_value = diff_wrap[VALUE_W-1:0];
      end else begin
         y_value = diff[VALUE_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      gen_one_in   = gen_one_ff;
      gen_two_in   = gen_two_ff;
      last_out_in  = last_out_ff;
      need_init_in = need_init_ff;
      init_cnt_in  = init_cnt_ff;
      quot_in      = quot_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      mm_req.valid   = 1'b0;
      mm_req.sel     = GEN_ONE;
      mm_req.operand = gen_one_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = quot_ff;
      ram_wr_data = gen_one_ff;
      ram_rd_en   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == ACT_RESEED) begin
                  gen_one_in   = (seed == '0) ? SEED_SUBST : seed;
                  need_init_in = 1'b1;
                  state_in     = S_INIT_SETUP;
               end else if (need_init_ff) begin
                  state_in = S_INIT_SETUP;
               end else begin
                  state_in = S_STEP_ONE;
               end
            end
         end

         S_INIT_SETUP: begin
            gen_two_in  = gen_one_ff;
            init_cnt_in = CW'(TABLE_SIZE + 7);
            state_in    = S_INIT_ISSUE;
         end

         S_INIT_ISSUE: begin
            mm_req.valid = 1'b1;
            state_in     = S_INIT_WAIT;
         end

         // warm-up steps first, then fill from the top slot down
         S_INIT_WAIT: begin
            if (mm_rsp.valid) begin
               gen_one_in  = mm_rsp.value;
               ram_wr_addr = init_cnt_ff[AW-1:0];
               ram_wr_data = mm_rsp.value;
               ram_wr_en   = (init_cnt_ff < CW'(TABLE_SIZE));
               if (init_cnt_ff == '0) begin
                  last_out_in  = mm_rsp.value;
                  need_init_in = 1'b0;
                  state_in     = S_STEP_ONE;
               end else begin
                  init_cnt_in = init_cnt_ff - 1'b1;
                  state_in    = S_INIT_ISSUE;
               end
            end
         end

         // issue gen_one, take the slot estimate
         S_STEP_ONE: begin
            mm_req.valid = 1'b1;
            quot_in      = slot_est[DW-1:VALUE_W];
            state_in     = S_STEP_TWO;
         end

         // issue gen_two, correct the slot by one if needed
         S_STEP_TWO: begin
            mm_req.valid   = 1'b1;
            mm_req.sel     = GEN_TWO;
            mm_req.operand = gen_two_ff;
            if (slot_bump) begin
               quot_in = quot_ff + 1'b1;
            end
            state_in       = S_STEP_WAIT;
         end

         // results return in issue order
         S_STEP_WAIT: begin
            if (mm_rsp.valid) begin
               if (mm_rsp.sel == GEN_TWO) begin
                  gen_two_in = mm_rsp.value;
                  state_in   = S_READ;
               end else begin
                  gen_one_in = mm_rsp.value;
               end
            end
         end

         S_READ: begin
            ram_rd_en = 1'b1;
            state_in  = S_COMBINE;
         end

         // output entry minus gen_two, refill slot with gen_one
         S_COMBINE: begin
            if (out_free) begin
               ram_wr_en    = 1'b1;
               last_out_in  = y_value;
               rsp_value_in = y_value;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gen_one_ff   <= VALUE_W'(1);
         gen_two_ff   <= VALUE_W'(123456789);
         last_out_ff  <= '0;
         need_init_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_one_ff   <= gen_one_in;
         gen_two_ff   <= gen_two_in;
         last_out_ff  <= last_out_in;
         need_init_ff <= need_init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      init_cnt_ff  <= init_cnt_in;
      quot_ff      <= quot_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_value_ff);

   // multiplier results only land while the sequencer waits for them
   a_mm_expected: assert property (@(posedge clock) disable iff (reset)
      mm_rsp.valid |-> (state_ff == S_INIT_WAIT || state_ff == S_STEP_WAIT))
      else $error("unexpected multiplier result");

   // a result appears only out of the combine step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_COMBINE))
      else $error("result raised outside combine");

   // the table slot stays inside the table
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> ((AW+1)'(quot_ff) < (AW+1)'(TABLE_SIZE)))
      else $error("shuffle slot out of range");

   // results stay within 1..M_ONE-1
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff != '0 && rsp_value_ff < M_ONE))
      else $error("result out of range");

   // initialization ends only after the last fill step
   a_init_done: assert property (@(posedge clock) disable iff (reset)
      $fell(need_init_ff) |-> $past(state_ff == S_INIT_WAIT && init_cnt_ff == '0))
      else $error("init ended early");

endmodule

`default_nettype wire

// File: verif/combined_lcg_shuffle_rng_test.sv
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng_test;
   import clsr_pkg::*;

   localparam int TABLE_SIZE = TABLE_SIZE_DEF;

   // Schrage factors for both generators
   localparam longint Q_ONE    = longint'(M_ONE) / longint'(A_ONE);
   localparam longint R_ONE    = longint'(M_ONE) % longint'(A_ONE);
   localparam longint Q_TWO    = longint'(M_TWO) / longint'(A_TWO);
   localparam longint R_TWO    = longint'(M_TWO) % longint'(A_TWO);
   localparam longint SLOT_DIV = 1 + (longint'(M_ONE) - 1) / TABLE_SIZE;

   localparam int TAIL_CYCLES  = 250;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int CHOKE_CYCLES = 600;

   typedef struct packed {
      logic               action;
      logic [VALUE_W-1:0] seed;
   } draw_req_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [30:0] seed, [31] zero
   logic                  req_tuser = 1'b0; // [0] action
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [30:0] value, [31] zero

   combined_lcg_shuffle_rng #(.TABLE_SIZE(TABLE_SIZE)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // predicted generator state
   longint rng_one     = 1;
   longint rng_two     = 123456789;
   longint prev_value  = 0;
   longint shuffle [TABLE_SIZE];
   bit     warm_needed = 1'b1;

   draw_req_type       pending_draws[$];
   logic [VALUE_W-1:0] expected_values[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  req_fired      = 1'b0;
   int  send_gap       = 0;
   int  recv_gap       = 0;
   int  send_odds      = 0;
   int  recv_odds      = 0;
   bit  choke_start    = 1'b0;
   bit  choke_begun    = 1'b0;
   int  choke_left     = 0;

   function automatic longint schrage(longint z, longint a, longint m, longint q, longint r);
      longint k;
      longint t;
      k = z / q;
      t = a * (z - k * q) - k * r;
      if (t < 0)
         t += m;
      return t;
   endfunction

   // advance the predicted state by one request and return its number
   function automatic logic [VALUE_W-1:0] draw_value(logic action, logic [VALUE_W-1:0] seed);
      longint mix;
      int     slot;
      if (action == ACT_RESEED) begin
         rng_one     = longint'(seed);
         warm_needed = 1'b1;
      end
      // warm-up: 8 discarded steps, then fill table top slot first
      if (warm_needed) begin
         if (rng_one < 1)
            rng_one = longint'(SEED_SUBST);
         rng_two = rng_one;
         for (int i = TABLE_SIZE + 7; i >= 0; i--) begin
            rng_one = schrage(rng_one, A_ONE, M_ONE, Q_ONE, R_ONE);
            if (i < TABLE_SIZE)
               shuffle[i] = rng_one;
         end
         prev_value  = shuffle[0];
         warm_needed = 1'b0;
      end
      rng_one = schrage(rng_one, A_ONE, M_ONE, Q_ONE, R_ONE);
      rng_two = schrage(rng_two, A_TWO, M_TWO, Q_TWO, R_TWO);
      slot = int'((prev_value / SLOT_DIV) % TABLE_SIZE);
      mix = shuffle[slot] - rng_two;
      shuffle[slot] = rng_one;
      if (mix < 1)
         mix += longint'(M_ONE) - 1;
      prev_value = mix;
      return mix[VALUE_W-1:0];
   endfunction

   function automatic draw_req_type make_random_draw();
      draw_req_type d;
      longint       s;
      d.action = ($urandom_range(24, 0) == 0) ? ACT_RESEED : ACT_NEXT;
      case ($urandom_range(9, 0))
         0: s = $urandom_range(4, 0);
         1: s = longint'(M_ONE) - 2 + $urandom_range(4, 0);
         2: s = longint'(M_TWO) - 2 + $urandom_range(4, 0);
         3: s = 64'h7FFF_FFFF - $urandom_range(3, 0);
         default: s = $urandom;
      endcase
      d.seed = s[VALUE_W-1:0];
      return d;
   endfunction

   task automatic queue_draw(logic action, logic [VALUE_W-1:0] seed);
      draw_req_type d;
      d.action = action;
      d.seed   = seed;
      pending_draws.push_back(d);
   endtask

   // step to a point between edges so queue updates never race the edges
   task automatic mid_cycle();
      @(posedge clock);
      #0.5;
   endtask

   task automatic wait_sent();
      while (pending_draws.size() != 0)
         mid_cycle();
   endtask

   task automatic wait_drained();
      while (pending_draws.size() != 0 || expected_values.size() != 0)
         mid_cycle();
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fired) begin
         // offer stands until taken
      end else if (send_gap > 0) begin
         send_gap--;
         req_tvalid <= 1'b0;
      end else if (pending_draws.size() == 0) begin
         req_tvalid <= 1'b0;
      end else if (send_odds != 0 && $urandom_range(send_odds - 1, 0) == 0) begin
         send_gap = $urandom_range(10, 0);
         req_tvalid <= 1'b0;
      end else begin
         req_tvalid <= 1'b1;
         req_tdata  <= {1'b0, pending_draws[0].seed};
         req_tuser  <= pending_draws[0].action;
      end
   end

   // result receiver, with one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (choke_start && !choke_begun) begin
            choke_begun = 1'b1;
            choke_left  = CHOKE_CYCLES;
         end
         if (choke_left > 0) begin
            choke_left--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (recv_odds != 0 && $urandom_range(recv_odds - 1, 0) == 0) begin
            recv_gap = $urandom_range(10, 0);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: check results, predict accepted requests
   always @(posedge clock) begin
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_values.size() == 0) begin
               $error("value: expected none, actual %0d", rsp_tdata[VALUE_W-1:0]);
               mismatch_count++;
            end else begin
               if (rsp_tdata[VALUE_W-1:0] !== expected_values[0]) begin
                  $error("value: expected %0d, actual %0d",
                         expected_values[0], rsp_tdata[VALUE_W-1:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[RSP_DATA_W-1] !== 1'b0) begin
                  $error("pad: expected 0, actual %b", rsp_tdata[RSP_DATA_W-1]);
                  mismatch_count++;
               end
               void'(expected_values.pop_front());
            end
         end
         req_fired = req_tvalid && req_tready;
         if (req_fired) begin
            expected_values.push_back(draw_value(pending_draws[0].action,
                                                 pending_draws[0].seed));
            void'(pending_draws.pop_front());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("combined_lcg_shuffle_rng verification failed");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      repeat (4) @(posedge clock);
      #0.5 reset = 1'b0;

      // directed: first request inits from reset state, seed corners
      send_odds = 4;
      recv_odds = 4;
      queue_draw(ACT_NEXT, '0);
      queue_draw(ACT_NEXT, '1);
      queue_draw(ACT_NEXT, 31'h2AAA_AAAA);
      queue_draw(ACT_RESEED, '0);
      queue_draw(ACT_NEXT, 31'h5555_5555);
      queue_draw(ACT_RESEED, 31'd1);
      queue_draw(ACT_RESEED, '1);
      queue_draw(ACT_NEXT, '0);
      // seed equal to the first modulus parks gen one at zero
      queue_draw(ACT_RESEED, M_ONE);
      queue_draw(ACT_NEXT, '0);
      queue_draw(ACT_NEXT, '1);
      queue_draw(ACT_NEXT, '0);
      queue_draw(ACT_RESEED, M_ONE - 31'd1);
      queue_draw(ACT_RESEED, M_ONE + 31'd1);
      queue_draw(ACT_RESEED, M_TWO);
      queue_draw(ACT_NEXT, '0);
      queue_draw(ACT_RESEED, M_TWO - 31'd1);
      queue_draw(ACT_RESEED, 31'h2AAA_AAAA);
      queue_draw(ACT_RESEED, 31'h5555_5555);
      queue_draw(ACT_NEXT, '1);
      queue_draw(ACT_NEXT, '0);
      queue_draw(ACT_NEXT, '0);
      wait_drained();

      // receiver holds off long while requests keep coming
      send_odds   = 0;
      recv_odds   = 6;
      choke_start = 1'b1;
      repeat (60)
         pending_draws.push_back(make_random_draw());
      wait_drained();

      // random chunks with varying idle density
      for (int c = 0; c < 17; c++) begin
         case ($urandom_range(2, 0))
            0: begin send_odds = 0; recv_odds = 0; end
            1: begin send_odds = 3; recv_odds = 3; end
            default: begin send_odds = 8; recv_odds = 8; end
         endcase
         repeat (100)
            pending_draws.push_back(make_random_draw());
         wait_sent();
      end
      wait_drained();

      // closing stretch at full rate
      send_odds = 0;
      recv_odds = 0;
      repeat (100)
         pending_draws.push_back(make_random_draw());
      wait_drained();

      // catch any stray result
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_values.size() == 0)
         $display("combined_lcg_shuffle_rng verification clean");
      else
         $display("combined_lcg_shuffle_rng verification failed");
      $finish;
   end

endmodule
